// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define CHK_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// a implies b in the next cycle
`define CHK_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/tlsk_pkg.sv =====
`timescale 1ns / 1ps
package tlsk_pkg;

    localparam int SYS_ENTRIES_DEF   = 1024 * 4;
    localparam int LOCAL_ENTRIES_DEF = 64;
    localparam int MAX_KEY_BYTES_DEF = 32;
    localparam int KEY_BYTES         = 32;
    localparam int HASH_BYTES_STEP   = 4;
    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [7:0]  BYTE_LIMIT = 8'd127;

    typedef enum logic [2:0] {
        OUT_EMPTY      = 3'd0,
        OUT_BYPASS     = 3'd1,
        OUT_SYS_HIT    = 3'd2,
        OUT_LOC_HIT    = 3'd3,
        OUT_INST_SYS   = 3'd4,
        OUT_INST_LOC   = 3'd5
    } outcome_t;

    typedef enum logic {
        REG_SYSTEM_MODE  = 1'b0,
        REG_EMPTY_HANDLE = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLASSIFY,
        ST_HASH,
        ST_READ,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic        start_of_document;
        logic [15:0] key_length;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [31:0] fresh_handle;
    } request_t;

    typedef struct packed {
        logic [31:0] handle;
        logic [2:0]  outcome;
        logic [31:0] hash_key;
    } result_t;

    typedef struct packed {
        logic [5:0]   len;
        logic [31:0]  key;
        logic [31:0]  handle;
        logic [255:0] bytes;
    } entry_t;

    typedef struct packed {
        logic load;
        logic classify;
        logic hash_step;
        logic rd_issue;
        logic decide;
        logic clr_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic early_done;
        logic system_mode;
        logic hash_last;
        logic clr_last;
    } ctrl_stat_t;

    function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] b);
        return (h << 5) + h + {{24{b[7]}}, b};
    endfunction

endpackage

// ===== rtl/two_level_string_key_cache.sv =====
`timescale 1ns / 1ps
// empty or bypass keys: load, classify, then the result is registered onto done;
//   others add read and decide; system mode first runs djb2, four bytes per cycle
// throughput: one key at a time, the next is accepted in the cycle done shows
// reset: after rst_n the system table is cleared one slot a cycle, all SYS_ENTRIES
//   slots (4096 by default), with busy high; configuration writes are taken meanwhile
// the receiver cannot stall, each result shows on done for exactly one cycle
module two_level_string_key_cache
    import tlsk_pkg::*;
#(
    parameter int SYS_ENTRIES   = SYS_ENTRIES_DEF,
    parameter int LOCAL_ENTRIES = LOCAL_ENTRIES_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  request_t    request,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    tlsk_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tlsk_datapath #(
        .SYS_ENTRIES   (SYS_ENTRIES),
        .LOCAL_ENTRIES (LOCAL_ENTRIES),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .done      (done)
    );

endmodule

// ===== rtl/tlsk_ctrl.sv =====
`timescale 1ns / 1ps
module tlsk_ctrl
    import tlsk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                if (stat.early_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.system_mode)
                begin
                    state_next = ST_HASH;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tlsk_datapath.sv =====
`timescale 1ns / 1ps
module tlsk_datapath
    import tlsk_pkg::*;
#(
    parameter int SYS_ENTRIES   = SYS_ENTRIES_DEF,
    parameter int LOCAL_ENTRIES = LOCAL_ENTRIES_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  request_t    request,
    input  ctrl_cmd_t   cmd,
    output ctrl_stat_t  stat,
    input  logic        cfg_valid,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output result_t     result,
    output logic        done
);

    localparam int SYS_AW    = $clog2(SYS_ENTRIES);
    localparam int LOC_SLOTS = 2 * LOCAL_ENTRIES;
    localparam int LOC_AW    = $clog2(LOC_SLOTS);

    // configuration
    logic        system_mode_reg;
    logic [31:0] empty_handle_reg;

    // item registers
    logic [15:0]  len_reg;
    logic [255:0] key_reg;
    logic [31:0]  fresh_reg;
    logic [31:0]  h_reg;
    logic [5:0]   pos_reg;

    // tables
    entry_t sys_mem [SYS_ENTRIES];
    entry_t loc_mem [LOC_SLOTS];
    entry_t sys_rd_reg;
    entry_t loc_rd_reg;
    logic [LOC_SLOTS-1:0] loc_valid_reg;
    logic                 loc_vld_rd_reg;
    logic [SYS_AW-1:0]    clr_idx_reg;

    result_t res_reg;
    result_t res_next;
    logic    done_reg;
    logic    done_next;

    logic [255:0] key_raw;
    logic [255:0] key_masked;
    logic [7:0]   b0;
    logic [7:0]   b_last;
    logic [4:0]   last_idx;
    logic         is_empty;
    logic         is_bypass;
    logic [31:0]  short_hash;
    logic [31:0]  h_step;
    logic [5:0]   idx_j;
    logic [SYS_AW-1:0] sidx;
    logic [LOC_AW-1:0] lidx;
    logic         sys_hit;
    logic         loc_hit;
    logic         save_sys;
    logic         sys_we;
    logic [SYS_AW-1:0] sys_waddr;
    entry_t       sys_wdata;
    entry_t       new_entry;

    assign key_raw = {request.key_word3, request.key_word2, request.key_word1,
                      request.key_word0};

    always_comb
    begin
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            key_masked[8*i +: 8] = (request.key_length > 16'(i))
                ? key_raw[8*i +: 8]
                : 8'd0;
        end
    end

    // classification of the loaded key
    assign b0        = key_reg[7:0];
    assign last_idx  = 5'(len_reg - 16'd1);
    assign b_last    = key_reg[8*last_idx +: 8];
    assign is_empty  = (len_reg == 16'd0);
    assign is_bypass = (b0 == 8'd0) || (b0 >= BYTE_LIMIT) ||
                       (len_reg > 16'(MAX_KEY_BYTES));
    assign short_hash = (len_reg > 16'd1) ? mix_byte(mix_byte(HASH_SEED, b0), b_last)
                                          : mix_byte(HASH_SEED, b0);

    // four bytes of djb2 per cycle
    always_comb
    begin
        h_step = h_reg;
        idx_j  = pos_reg;
        for (int j = 0; j < HASH_BYTES_STEP; j++)
        begin
            idx_j = pos_reg + 6'(j);
            if ({10'd0, idx_j} < len_reg)
            begin
                h_step = mix_byte(h_step, key_reg[8*idx_j[4:0] +: 8]);
            end
        end
    end

    assign sidx = h_reg[SYS_AW-1:0];
    assign lidx = system_mode_reg ? {1'b0, h_reg[LOC_AW-2:0]} : h_reg[LOC_AW-1:0];

    assign stat.early_done  = is_empty || is_bypass;
    assign stat.system_mode = system_mode_reg;
    assign stat.hash_last   = ({10'd0, pos_reg} + 16'(HASH_BYTES_STEP)) >= len_reg;
    assign stat.clr_last    = &clr_idx_reg;

    assign new_entry.len    = len_reg[5:0];
    assign new_entry.key    = h_reg;
    assign new_entry.handle = fresh_reg;
    assign new_entry.bytes  = key_reg;

    assign sys_hit = system_mode_reg && (sys_rd_reg.len == len_reg[5:0]) &&
                     (sys_rd_reg.key == h_reg) && (sys_rd_reg.bytes == key_reg);
    assign loc_hit = loc_vld_rd_reg && (loc_rd_reg.len == len_reg[5:0]) &&
                     (loc_rd_reg.key == h_reg) && (loc_rd_reg.bytes == key_reg);
    assign save_sys = system_mode_reg && (sys_rd_reg.len == 6'd0);

    always_comb
    begin
        sys_we    = 1'b0;
        sys_waddr = sidx;
        sys_wdata = new_entry;
        if (cmd.clr_step)
        begin
            sys_we    = 1'b1;
            sys_waddr = clr_idx_reg;
            sys_wdata = '0;
        end
        else if (cmd.decide && !sys_hit && !loc_hit && save_sys)
        begin
            sys_we = 1'b1;
        end
    end

    always_comb
    begin
        res_next  = res_reg;
        done_next = 1'b0;
        if (cmd.classify && is_empty)
        begin
            res_next  = '{handle: empty_handle_reg, outcome: OUT_EMPTY, hash_key: 32'd0};
            done_next = 1'b1;
        end
        else if (cmd.classify && is_bypass)
        begin
            res_next  = '{handle: fresh_reg, outcome: OUT_BYPASS, hash_key: 32'd0};
            done_next = 1'b1;
        end
        else if (cmd.decide)
        begin
            done_next = 1'b1;
            if (sys_hit)
            begin
                res_next = '{handle: sys_rd_reg.handle, outcome: OUT_SYS_HIT, hash_key: h_reg};
            end
            else if (loc_hit)
            begin
                res_next = '{handle: loc_rd_reg.handle, outcome: OUT_LOC_HIT, hash_key: h_reg};
            end
            else if (save_sys)
            begin
                res_next = '{handle: fresh_reg, outcome: OUT_INST_SYS, hash_key: h_reg};
            end
            else
            begin
                res_next = '{handle: fresh_reg, outcome: OUT_INST_LOC, hash_key: h_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            system_mode_reg  <= 1'b0;
            empty_handle_reg <= 32'd0;
            loc_valid_reg    <= '0;
            clr_idx_reg      <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SYSTEM_MODE:  system_mode_reg  <= cfg_data[0];
                    REG_EMPTY_HANDLE: empty_handle_reg <= cfg_data;
                    default:          empty_handle_reg <= empty_handle_reg;
                endcase
            end
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.load && request.start_of_document)
            begin
                loc_valid_reg <= '0;
            end
            else if (cmd.decide && !sys_hit && !loc_hit && !save_sys)
            begin
                loc_valid_reg[lidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.load)
        begin
            len_reg   <= request.key_length;
            key_reg   <= key_masked;
            fresh_reg <= request.fresh_handle;
        end
        if (cmd.classify)
        begin
            h_reg   <= system_mode_reg ? HASH_SEED : short_hash;
            pos_reg <= 6'd0;
        end
        else if (cmd.hash_step)
        begin
            h_reg   <= h_step;
            pos_reg <= pos_reg + 6'(HASH_BYTES_STEP);
        end
        if (cmd.rd_issue)
        begin
            loc_vld_rd_reg <= loc_valid_reg[lidx];
        end
    end

    // system table
    always_ff @(posedge clk)
    begin
        if (sys_we)
        begin
            sys_mem[sys_waddr] <= sys_wdata;
        end
        if (cmd.rd_issue)
        begin
            sys_rd_reg <= sys_mem[sidx];
        end
    end

    // local table, valid bits stand for the reset value
    always_ff @(posedge clk)
    begin
        if (cmd.decide && !sys_hit && !loc_hit && !save_sys)
        begin
            loc_mem[lidx] <= new_entry;
        end
        if (cmd.rd_issue)
        begin
            loc_rd_reg <= loc_mem[lidx];
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/tlsk_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tlsk_checker
    import tlsk_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    `CHK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted transaction did not raise busy")
    `CHK_SAME(a_done_from_busy, clk, rst_n, done, $past(busy), "result without a transaction in flight")
    `CHK_NEXT(a_single_result, clk, rst_n, done, !done, "two results for one transaction")
    `CHK_SAME(a_outcome_code, clk, rst_n, done, (result.outcome != 3'd6) && (result.outcome != 3'd7), "outcome code out of range")
    `CHK_SAME(a_unhashed_zero, clk, rst_n, done && ((result.outcome == OUT_EMPTY) || (result.outcome == OUT_BYPASS)), result.hash_key == 32'd0, "hash key set on unhashed key")

endmodule

bind two_level_string_key_cache tlsk_checker u_tlsk_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
